### rtl/core/kth_smallest_distance_tracker_core_defines.svh
// Assertion macros shared by the distance tracker RTL.
// Depends on nothing; taken in by the top level with an include.
`ifndef KTH_SMALLEST_DISTANCE_TRACKER_CORE_DEFINES_SVH
`define KTH_SMALLEST_DISTANCE_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KSTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KSTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/kstd_pkg.sv
// Shared constants, controller states and command/status words for the
// distance tracker. Depends on nothing.
package kstd_pkg;

  // Capacity of the heap store.
  localparam int MAX_KEEP = 64;
  localparam int ADDR_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);
  localparam int CH_W     = ADDR_W + 2;
  localparam int COORD_W  = 16;
  localparam int DIST_W   = 32;
  localparam int KEEP_W   = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_SUM,
    ST_DECIDE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_RD_L,
    ST_DN_RD_R,
    ST_DN_CMP,
    ST_DONE
  } kstd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_pt;
    logic square;
    logic sum;
    logic ins_start;
    logic up_read;
    logic up_move;
    logic place;
    logic dn_start;
    logic dn_read_l;
    logic dn_read_r;
    logic dn_move;
  } kstd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic held_lt_k;
    logic dist_lt_top;
    logic hole_zero;
    logic parent_lt_dist;
    logic has_left;
    logic child_gt_dist;
  } kstd_sts_t;

endpackage

### rtl/core/kstd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module kstd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/kstd_ctrl.sv
// Controller for the distance tracker: sequences squaring, heap insert
// (sift-up) and root replacement (sift-down). Depends on kstd_pkg.
module kstd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  kstd_pkg::kstd_sts_t sts,
  output kstd_pkg::kstd_cmd_t cmd,
  output logic              busy,
  output logic              done
);

  kstd_pkg::kstd_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kstd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      kstd_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_pt = 1'b1;
          state_next  = kstd_pkg::ST_SQR;
        end
      end
      kstd_pkg::ST_SQR: begin
        cmd.square = 1'b1;
        state_next = kstd_pkg::ST_SUM;
      end
      kstd_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = kstd_pkg::ST_DECIDE;
      end
      kstd_pkg::ST_DECIDE: begin
        if (sts.held_lt_k) begin
          cmd.ins_start = 1'b1;
          state_next    = kstd_pkg::ST_UP_CHK;
        end else if (sts.dist_lt_top) begin
          cmd.dn_start = 1'b1;
          state_next   = kstd_pkg::ST_DN_RD_L;
        end else begin
          state_next = kstd_pkg::ST_DONE;
        end
      end
      kstd_pkg::ST_UP_CHK: begin
        if (sts.hole_zero) begin
          cmd.place  = 1'b1;
          state_next = kstd_pkg::ST_DONE;
        end else begin
          cmd.up_read = 1'b1;
          state_next  = kstd_pkg::ST_UP_CMP;
        end
      end
      kstd_pkg::ST_UP_CMP: begin
        if (sts.parent_lt_dist) begin
          cmd.up_move = 1'b1;
          state_next  = kstd_pkg::ST_UP_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = kstd_pkg::ST_DONE;
        end
      end
      kstd_pkg::ST_DN_RD_L: begin
        if (sts.has_left) begin
          cmd.dn_read_l = 1'b1;
          state_next    = kstd_pkg::ST_DN_RD_R;
        end else begin
          cmd.place  = 1'b1;
          state_next = kstd_pkg::ST_DONE;
        end
      end
      kstd_pkg::ST_DN_RD_R: begin
        cmd.dn_read_r = 1'b1;
        state_next    = kstd_pkg::ST_DN_CMP;
      end
      kstd_pkg::ST_DN_CMP: begin
        if (sts.child_gt_dist) begin
          cmd.dn_move = 1'b1;
          state_next  = kstd_pkg::ST_DN_RD_L;
        end else begin
          cmd.place  = 1'b1;
          state_next = kstd_pkg::ST_DONE;
        end
      end
      kstd_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = kstd_pkg::ST_IDLE;
      end
      default: begin
        state_next = kstd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/kstd_dp.sv
// Datapath for the distance tracker: squaring, max-heap store, hole index,
// fill count and k register. Depends on kstd_pkg and kstd_ram.
module kstd_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  kstd_pkg::kstd_cmd_t               cmd,
  output kstd_pkg::kstd_sts_t               sts,
  input  logic signed [kstd_pkg::COORD_W-1:0] point_x,
  input  logic signed [kstd_pkg::COORD_W-1:0] point_y,
  input  logic                              cfg_we,
  input  logic [kstd_pkg::KEEP_W-1:0]       keep_count,
  output logic [kstd_pkg::DIST_W-1:0]       kth_distance,
  output logic                              kth_valid
);

  logic signed [kstd_pkg::COORD_W-1:0] px, py;
  logic [kstd_pkg::COORD_W-1:0]        mag_x, mag_y;
  logic [kstd_pkg::DIST_W-1:0]         sq_x, sq_y, pt_dist, top, lval;
  logic [kstd_pkg::ADDR_W-1:0]         hole, parent;
  logic [kstd_pkg::CH_W-1:0]           left, right, held_w;
  logic [kstd_pkg::CNT_W-1:0]          held, keep_k;
  logic [kstd_pkg::CNT_W-1:0]          keep_sat;
  logic                                has_right, pick_right;
  logic [kstd_pkg::DIST_W-1:0]         cval;
  logic [kstd_pkg::ADDR_W-1:0]         cidx;
  logic                                we;
  logic [kstd_pkg::ADDR_W-1:0]         raddr;
  logic [kstd_pkg::DIST_W-1:0]         wdata, rdata;

  // Magnitudes of the coordinates; the most negative value maps to 2^15.
  assign mag_x = px[kstd_pkg::COORD_W-1] ? (~px + 1'b1) : px;
  assign mag_y = py[kstd_pkg::COORD_W-1] ? (~py + 1'b1) : py;

  // Effective k: zero reads as one, large values saturate at capacity.
  always_comb begin
    if (keep_count == '0) begin
      keep_sat = kstd_pkg::CNT_W'(1);
    end else if (32'(keep_count) > kstd_pkg::MAX_KEEP) begin
      keep_sat = kstd_pkg::CNT_W'(kstd_pkg::MAX_KEEP);
    end else begin
      keep_sat = kstd_pkg::CNT_W'(keep_count);
    end
  end

  // Heap neighbours of the hole.
  assign parent = (hole - 1'b1) >> 1;
  assign left   = {1'b0, hole, 1'b1};
  assign right  = {1'b0, hole, 1'b0} + kstd_pkg::CH_W'(2);
  assign held_w = kstd_pkg::CH_W'(held);

  // Larger child; the right word is on the read port in the compare cycle.
  assign has_right  = right < held_w;
  assign pick_right = has_right && (rdata > lval);
  assign cval       = pick_right ? rdata : lval;
  assign cidx       = pick_right ? right[kstd_pkg::ADDR_W-1:0] : left[kstd_pkg::ADDR_W-1:0];

  // Status towards the controller.
  always_comb begin
    sts.held_lt_k      = held < keep_k;
    sts.dist_lt_top    = pt_dist < top;
    sts.hole_zero      = hole == '0;
    sts.parent_lt_dist = rdata < pt_dist;
    sts.has_left       = left < held_w;
    sts.child_gt_dist  = cval > pt_dist;
  end

  // Heap store write and read selection.
  assign we = cmd.place | cmd.up_move | cmd.dn_move;
  always_comb begin
    if (cmd.up_move) begin
      wdata = rdata;
    end else if (cmd.dn_move) begin
      wdata = cval;
    end else begin
      wdata = pt_dist;
    end
    if (cmd.up_read) begin
      raddr = parent;
    end else if (cmd.dn_read_r) begin
      raddr = right[kstd_pkg::ADDR_W-1:0];
    end else if (cmd.dn_read_l) begin
      raddr = left[kstd_pkg::ADDR_W-1:0];
    end else begin
      raddr = '0;
    end
  end

  kstd_ram #(
    .WIDTH (kstd_pkg::DIST_W),
    .DEPTH (kstd_pkg::MAX_KEEP)
  ) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (hole),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control registers: fill count and k.
  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= '0;
      keep_k <= kstd_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      held   <= '0;
      keep_k <= keep_sat;
    end else if (cmd.ins_start) begin
      held <= held + 1'b1;
    end
  end

  // Payload registers: point, squares, distance, hole, left child, root copy.
  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      px <= point_x;
      py <= point_y;
    end
    if (cmd.square) begin
      sq_x <= kstd_pkg::DIST_W'(mag_x * mag_x);
      sq_y <= kstd_pkg::DIST_W'(mag_y * mag_y);
    end
    if (cmd.sum) begin
      pt_dist <= sq_x + sq_y;
    end
    if (cmd.ins_start) begin
      hole <= held[kstd_pkg::ADDR_W-1:0];
    end else if (cmd.dn_start) begin
      hole <= '0;
    end else if (cmd.up_move) begin
      hole <= parent;
    end else if (cmd.dn_move) begin
      hole <= cidx;
    end
    if (cmd.dn_read_r) begin
      lval <= rdata;
    end
    // The root is mirrored so the largest kept value is always on hand.
    if (we && (hole == '0)) begin
      top <= wdata;
    end
  end

  assign kth_distance = (held == '0) ? '0 : top;
  assign kth_valid    = held == keep_k;

endmodule

### rtl/core/kth_smallest_distance_tracker_core.sv
// With no heap update the result follows the squaring and the sum; an insert sifts up,
// and a replacement of the root sifts down, through the single-read-port heap store. The
// controller passes through idle between items, so the next point is taken only once
// the last one is done.
// The result is shown for one cycle with done; the receiver cannot stall.
// Synchronous reset: the kept set is emptied and k returns to one.
`include "kth_smallest_distance_tracker_core_defines.svh"

module kth_smallest_distance_tracker_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [kstd_pkg::COORD_W-1:0] point_x,
  input  logic signed [kstd_pkg::COORD_W-1:0] point_y,
  output logic                              done,
  output logic [kstd_pkg::DIST_W-1:0]       kth_distance,
  output logic                              kth_valid,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kstd_pkg::KEEP_W-1:0]       keep_count
);

  kstd_pkg::kstd_cmd_t cmd;
  kstd_pkg::kstd_sts_t sts;
  logic                cfg_we;

  // Configuration words are taken only between items.
  assign cfg_ready = ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  kstd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  kstd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .point_x      (point_x),
    .point_y      (point_y),
    .cfg_we       (cfg_we),
    .keep_count   (keep_count),
    .kth_distance (kth_distance),
    .kth_valid    (kth_valid)
  );

  // Checks on the sequencing and on the fill count.
  `KSTD_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done, "busy not raised")
  `KSTD_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy && !done, "no idle after done")
  `KSTD_ASSERT_NEXT(a_cfg_clears, clk, rst, cfg_valid && cfg_ready, !kth_valid, "set not emptied")

endmodule

### sim/kth_smallest_distance_tracker_core_test.sv
// Self-checking testbench for the k smallest squared distance tracker core.
// Depends on kstd_pkg and kth_smallest_distance_tracker_core; it predicts
// each result word from its own copy of the kept set and compares it on done.
module kth_smallest_distance_tracker_core_test;
  import kstd_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int CALM_TAIL     = 150;
  localparam int SETTLE_CYCLES = 40;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [DIST_W-1:0] top_dist;
    logic              full;
  } kth_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  coord_t              point_x = '0;
  coord_t              point_y = '0;
  logic                done;
  logic [DIST_W-1:0]   kth_distance;
  logic                kth_valid;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [KEEP_W-1:0]   keep_count = '0;

  // Predicted state of the block: the kept distances, how many are held and k.
  logic [DIST_W-1:0]   kept_dist [MAX_KEEP];
  int                  held_n = 0;
  logic [KEEP_W-1:0]   keep_reg = 1;

  kth_result_t         pending_results [$];
  int                  fail_count = 0;
  int                  stall_cycles = 0;

  kth_smallest_distance_tracker_core uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .point_x      (point_x),
    .point_y      (point_y),
    .done         (done),
    .kth_distance (kth_distance),
    .kth_valid    (kth_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .keep_count   (keep_count)
  );

  always #4 clk = ~clk;

  // k as the block uses it: zero counts as one, and it never exceeds the store.
  function automatic int keep_limit(input logic [KEEP_W-1:0] k);
    int lim;
    lim = k;
    if (lim == 0) lim = 1;
    if (lim > MAX_KEEP) lim = MAX_KEEP;
    return lim;
  endfunction

  // Slot of the largest held distance; ties go to the lowest slot.
  function automatic int largest_slot();
    int best;
    best = 0;
    for (int i = 1; i < held_n; i++) begin
      if (kept_dist[i] > kept_dist[best]) best = i;
    end
    return best;
  endfunction

  // Folds one point into the kept set and returns the word the block should report.
  function automatic kth_result_t track_point(input coord_t x, input coord_t y);
    longint      ax;
    longint      ay;
    logic [DIST_W-1:0] d;
    int          lim;
    int          m;
    kth_result_t res;
    ax  = (x < 0) ? -longint'(x) : longint'(x);
    ay  = (y < 0) ? -longint'(y) : longint'(y);
    d   = DIST_W'(ax * ax + ay * ay);
    lim = keep_limit(keep_reg);
    if (held_n > lim) held_n = lim;
    if (held_n < lim) begin
      kept_dist[held_n] = d;
      held_n++;
    end else begin
      m = largest_slot();
      if (d < kept_dist[m]) kept_dist[m] = d;
    end
    res.top_dist = (held_n > 0) ? kept_dist[largest_slot()] : '0;
    res.full     = (held_n == lim);
    return res;
  endfunction

  // A coordinate drawn from the full range, near the extremes or close to zero.
  function automatic coord_t pick_coord();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = int'($urandom_range(0, 16)) - 8;
      7:          v = 32767 - int'($urandom_range(0, 3));
      8:          v = -32768 + int'($urandom_range(0, 3));
      default:    v = int'($urandom_range(0, 2)) - 1;
    endcase
    return coord_t'(v);
  endfunction

  // Presents one point and waits until the block takes the word.
  task automatic send_point(input coord_t x, input coord_t y);
    kth_result_t pred;
    @(negedge clk);
    start   <= 1'b1;
    point_x <= x;
    point_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred            = track_point(x, y);
    pending_results = {pending_results, pred};
  endtask

  // Holds start low for a number of cycles with noise on the coordinates.
  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start   <= 1'b0;
      point_x <= coord_t'($urandom);
      point_y <= coord_t'($urandom);
    end
  endtask

  // Stops sending and waits until every expected word has come back.
  task automatic drain_results();
    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes k while the block is idle; the kept set starts again from empty.
  task automatic write_keep(input logic [KEEP_W-1:0] k);
    drain_results();
    @(negedge clk);
    cfg_valid  <= 1'b1;
    keep_count <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    keep_reg = k;
    held_n   = 0;
    @(negedge clk);
    cfg_valid  <= 1'b0;
    keep_count <= KEEP_W'($urandom);
  endtask

  // Result checking against the oldest prediction, plus the stall watchdog.
  always @(posedge clk) begin
    kth_result_t exp_res;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result word with none expected: kth_distance %0d kth_valid %0b",
                 kth_distance, kth_valid);
          fail_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (kth_distance !== exp_res.top_dist) begin
            $error("kth_distance: expected %0d, got %0d", exp_res.top_dist, kth_distance);
            fail_count++;
          end
          if (kth_valid !== exp_res.full) begin
            $error("kth_valid: expected %0b, got %0b", exp_res.full, kth_valid);
            fail_count++;
          end
        end
      end
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("kth_smallest_distance_tracker_core_test failed");
        $finish;
      end
    end
  end

  // With k at its reset value of one: the extremes of both coordinates and points at or near zero.
  task automatic test_reset_keep();
    send_point(-16'sd32768, -16'sd32768);
    send_point(16'sd32767, 16'sd32767);
    send_point(16'sd32767, -16'sd32768);
    send_point(16'sd0, 16'sd0);
    send_point(-16'sd1, 16'sd1);
    send_point(16'sd0, 16'sd0);
  endtask

  // Equal distances: an equal one is refused, and the lowest slot goes first.
  task automatic test_ties();
    write_keep(3);
    send_point(16'sd3, 16'sd4);
    send_point(16'sd5, 16'sd0);
    send_point(-16'sd4, -16'sd3);
    send_point(16'sd0, -16'sd5);
    send_point(16'sd1, 16'sd1);
    send_point(-16'sd2, 16'sd0);
    send_point(16'sd1, 16'sd0);
  endtask

  // k of zero behaves as one, and a k above the store saturates.
  task automatic test_keep_limits();
    write_keep(0);
    send_point(16'sd7, 16'sd7);
    send_point(16'sd2, -16'sd2);
    write_keep(127);
    send_point(16'sd1, 16'sd2);
    send_point(-16'sd3, 16'sd4);
    send_point(-16'sd32768, 16'sd0);
  endtask

  // Phases of random points under varied k, with bursts of idle cycles.
  task automatic test_random_points();
    int             sent;
    int             count;
    int             idle_pct;
    logic [KEEP_W-1:0] k;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       k = 1;
        1:       k = 64;
        2:       k = 0;
        3:       k = 127;
        4, 5:    k = KEEP_W'($urandom_range(9, 70));
        default: k = KEEP_W'($urandom_range(2, 8));
      endcase
      write_keep(k);
      count    = keep_limit(k) + int'($urandom_range(10, 40));
      idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      for (int i = 0; i < count && sent < RANDOM_ITEMS; i++) begin
        if (sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 99) < idle_pct) begin
          pause_sender($urandom_range(1, 8));
        end
        send_point(pick_coord(), pick_coord());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_keep();
    test_ties();
    test_keep_limits();
    test_random_points();

    // Let the last words arrive, then wait out the settle time for any stray one.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("kth_smallest_distance_tracker_core_test passed");
    end else begin
      $display("kth_smallest_distance_tracker_core_test failed");
    end
    $finish;
  end

endmodule
